FILE: rtl/pip_pkg.sv
// shared constants and codes for the point in polygon test block
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 32;

  // fixed widths of the stream fields
  localparam int FIELD_W  = 32;
  localparam int IN_W     = 2 * FIELD_W;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = 8;
  localparam int OUT_PAD  = OUT_W - STATUS_W - 1;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

FILE: rtl/point_in_polygon_test.sv
// point in polygon test: vertex store, bounding box and even-odd ray cast
//
// The block keeps one closed polygon of up to MAX_VERTICES vertices. A clear word
// (tuser 0) empties it, an append word (tuser 1) adds the vertex in tdata, a query
// word (tuser 2) asks whether the point in tdata lies inside. Every input word gives
// exactly one output word with inside_res and status. Coordinates are the low
// COORD_WIDTH bits of each 32-bit field, read as two's complement. Appending to a
// full store drops the vertex with status 1; a query on an empty polygon answers
// outside with status 2. One word is worked on at a time. Clear, append, a query on
// an empty polygon and a query outside the bounding box go from decode straight to
// the reply. A query inside the box walks the n stored edges through a single
// shared unsigned multiplier and one magnitude compare; each edge whose y span
// straddles the query y needs two products and a compare, one per cycle. The vertex
// memory has one read port with registered data, so the edge walk reads one vertex
// per edge and keeps the previous one in a register. A result waits in the output
// register while the next word is accepted.
module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // input words
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // coord_x [31:0], coord_y [63:32]
  input  logic [MODE_W-1:0] s_tuser,   // mode [1:0]
  // result words
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // inside_res [0], status [2:1], zero [7:3]
);

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_VERTICES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PREV,
    S_DIFF,
    S_MUL1,
    S_MUL2,
    S_CMP,
    S_REPLY
  } state_t;

  state_t state;

  // latched input word
  logic [MODE_W-1:0]      mode;
  logic signed [CW-1:0]   px;
  logic signed [CW-1:0]   py;

  // polygon state
  logic [CNTW-1:0]        vertex_count;
  logic signed [CW-1:0]   box_min_x;
  logic signed [CW-1:0]   box_max_x;
  logic signed [CW-1:0]   box_min_y;
  logic signed [CW-1:0]   box_max_y;

  // vertex memory, one write and one registered read port
  logic signed [CW-1:0]   vertex_x_store [MAX_VERTICES];
  logic signed [CW-1:0]   vertex_y_store [MAX_VERTICES];
  logic signed [CW-1:0]   rd_x;
  logic signed [CW-1:0]   rd_y;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;

  // edge walk
  logic [CNTW-1:0]        idx;
  logic [CNTW-1:0]        idx_inc;
  logic [CNTW-1:0]        count_m1;
  logic signed [CW-1:0]   prev_x;
  logic signed [CW-1:0]   prev_y;
  logic [CW-1:0]          mag_px;
  logic [CW-1:0]          mag_dy;
  logic [CW-1:0]          mag_ex;
  logic [CW-1:0]          mag_ty;
  logic                   lhs_neg;
  logic                   rhs_neg;
  logic [2*CW-1:0]        lhs_mag;
  logic [2*CW-1:0]        rhs_mag;

  // shared multiplier
  logic [CW-1:0]          mul_a;
  logic [CW-1:0]          mul_b;
  logic [2*CW-1:0]        prod;

  // pending result
  logic                   res_inside;
  logic [STATUS_W-1:0]    res_status;

  // differences for the current edge, one bit wider than a coordinate
  logic signed [CW:0]     dpx;
  logic signed [CW:0]     dex;
  logic signed [CW:0]     dy;
  logic signed [CW:0]     ty;
  logic                   straddle;
  logic                   out_box;
  logic                   lhs_lt;
  logic                   lneg;
  logic                   rneg;
  logic                   out_free;

  function automatic logic [CW-1:0] mag_of(input logic signed [CW:0] v);
    logic [CW:0] n;
    n = ~v + {{CW{1'b0}}, 1'b1};
    return v[CW] ? n[CW-1:0] : v[CW-1:0];
  endfunction

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign idx_inc  = idx + 1'b1;
  assign count_m1 = vertex_count - 1'b1;

  // read address: closing-edge vertex first, then prefetch one ahead in the walk
  always_comb begin
    unique case (state)
      S_DECODE: rd_addr = count_m1[AW-1:0];
      S_DIFF:   rd_addr = idx_inc[AW-1:0];
      default:  rd_addr = idx[AW-1:0];
    endcase
  end

  assign wr_en = (state == S_DECODE) && (mode == MODE_APPEND) && (vertex_count < MAX_CNT);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vertex_x_store[vertex_count[AW-1:0]] <= px;
      vertex_y_store[vertex_count[AW-1:0]] <= py;
    end
    rd_x <= vertex_x_store[rd_addr];
    rd_y <= vertex_y_store[rd_addr];
  end

  assign out_box = (px < box_min_x) || (px > box_max_x) ||
                   (py < box_min_y) || (py > box_max_y);

  // current edge runs from the previous vertex (j) to the one just read (i)
  assign straddle = (rd_y > py) != (prev_y > py);
  assign dpx = {px[CW-1], px}         - {rd_x[CW-1], rd_x};
  assign dex = {prev_x[CW-1], prev_x} - {rd_x[CW-1], rd_x};
  assign dy  = {prev_y[CW-1], prev_y} - {rd_y[CW-1], rd_y};
  assign ty  = {py[CW-1], py}         - {rd_y[CW-1], rd_y};

  // lhs = |px - xi| * |dy|, rhs = |xj - xi| * |py - yi|, signs carried apart
  assign mul_a = (state == S_MUL1) ? mag_px : mag_ex;
  assign mul_b = (state == S_MUL1) ? mag_dy : mag_ty;
  assign prod  = mul_a * mul_b;

  // sign-magnitude less-than, a zero product counts as positive
  assign lneg = lhs_neg && (lhs_mag != '0);
  assign rneg = rhs_neg && (rhs_mag != '0);
  always_comb begin
    if (lneg != rneg) begin
      lhs_lt = lneg;
    end else if (!lneg) begin
      lhs_lt = lhs_mag < rhs_mag;
    end else begin
      lhs_lt = lhs_mag > rhs_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      vertex_count <= '0;
      box_min_x    <= '0;
      box_max_x    <= '0;
      box_min_y    <= '0;
      box_max_y    <= '0;
    end else begin
      // a reply that goes out this cycle reloads the output register instead
      if (m_tvalid && m_tready && (state != S_REPLY)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode  <= s_tuser;
            px    <= s_tdata[CW-1:0];
            py    <= s_tdata[FIELD_W+CW-1:FIELD_W];
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_inside <= 1'b0;
          idx        <= '0;
          unique case (mode)
            MODE_CLEAR: begin
              res_status   <= STATUS_OK;
              state        <= S_REPLY;
              vertex_count <= '0;
              box_min_x    <= '0;
              box_max_x    <= '0;
              box_min_y    <= '0;
              box_max_y    <= '0;
            end
            MODE_APPEND: begin
              state <= S_REPLY;
              if (vertex_count >= MAX_CNT) begin
                res_status <= STATUS_FULL;
              end else begin
                res_status   <= STATUS_OK;
                vertex_count <= vertex_count + 1'b1;
                if (vertex_count == '0) begin
                  // first vertex sets the box
                  box_min_x <= px;
                  box_max_x <= px;
                  box_min_y <= py;
                  box_max_y <= py;
                end else begin
                  if (px < box_min_x) box_min_x <= px;
                  if (px > box_max_x) box_max_x <= px;
                  if (py < box_min_y) box_min_y <= py;
                  if (py > box_max_y) box_max_y <= py;
                end
              end
            end
            MODE_QUERY: begin
              if (vertex_count == '0) begin
                res_status <= STATUS_EMPTY;
                state      <= S_REPLY;
              end else if (!out_box) begin
                res_status <= STATUS_OK;
                state      <= S_PREV;
              end else begin
                res_status <= STATUS_OK;
                state      <= S_REPLY;
              end
            end
            default: begin
              // unused kind, polygon left unchanged
              res_status <= STATUS_OK;
              state      <= S_REPLY;
            end
          endcase
        end
        S_PREV: begin
          // closing-edge vertex arrives, vertex 0 is on its way
          prev_x <= rd_x;
          prev_y <= rd_y;
          state  <= S_DIFF;
        end
        S_DIFF: begin
          prev_x <= rd_x;
          prev_y <= rd_y;
          idx    <= idx_inc;
          if (straddle) begin
            mag_px  <= mag_of(dpx);
            mag_dy  <= mag_of(dy);
            mag_ex  <= mag_of(dex);
            mag_ty  <= mag_of(ty);
            lhs_neg <= dpx[CW];
            // folding the sign of dy into the right side keeps the divisor positive
            rhs_neg <= dex[CW] ^ ty[CW] ^ dy[CW];
            state   <= S_MUL1;
          end else if (idx_inc == vertex_count) begin
            state <= S_REPLY;
          end
        end
        S_MUL1: begin
          lhs_mag <= prod;
          state   <= S_MUL2;
        end
        S_MUL2: begin
          rhs_mag <= prod;
          state   <= S_CMP;
        end
        S_CMP: begin
          if (lhs_lt) begin
            res_inside <= !res_inside;
          end
          state <= (idx == vertex_count) ? S_REPLY : S_DIFF;
        end
        S_REPLY: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{OUT_PAD{1'b0}}, res_status, res_inside};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    vertex_count <= MAX_CNT)
    else $error("vertex count beyond store depth");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    (vertex_count != '0) |-> (box_min_x <= box_max_x) && (box_min_y <= box_max_y))
    else $error("bounding box inverted");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIFF) |-> (idx < vertex_count))
    else $error("edge walk past last vertex");

  a_inside_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[STATUS_W:1] == STATUS_OK))
    else $error("inside reported with error status");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPLY) && out_free |=> m_tvalid && (state == S_IDLE))
    else $error("result not loaded on reply");
`endif

endmodule
